>>> src/obrb_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
// No dependencies; obrb_if, obrb_ctrl and the top level import this package.
`timescale 1ns / 1ps

package obrb_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int ACT_W  = 3;
   localparam int BYTE_W = 8;
   localparam int AMT_W  = 6;
   localparam int LEN_W  = 6;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUT        = 3'd0,
      ACT_POP_FRONT  = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONTN = 3'd3,
      ACT_POP_BACKN  = 3'd4,
      ACT_READ       = 3'd5,
      ACT_CLEAR      = 3'd6
   } action_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Per-transfer outcome handed from the pointer logic to the result stage
   typedef struct packed {
      logic             status;
      logic             read_hit;
      logic             full_flag;
      logic             empty_flag;
      logic [LEN_W-1:0] length;
   } step_result_type;

endpackage

>>> src/obrb_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on obrb_pkg for field widths.
`timescale 1ns / 1ps

interface obrb_req_if;
   import obrb_pkg::*;
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] byte_in;
   logic [AMT_W-1:0]  amount;

   modport source (output valid, action, byte_in, amount, input ready);
   modport sink   (input valid, action, byte_in, amount, output ready);
endinterface

interface obrb_rsp_if;
   import obrb_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [BYTE_W-1:0] byte_out;
   logic [LEN_W-1:0]  length;
   logic              full_flag;
   logic              empty_flag;

   modport source (output valid, status, byte_out, length, full_flag, empty_flag,
                   input ready);
   modport sink   (input valid, status, byte_out, length, full_flag, empty_flag,
                   output ready);
endinterface

>>> src/obrb_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module obrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/obrb_ctrl.sv
// Head, tail and count registers with the action decode; drives the slot RAM.
// Depends on obrb_pkg.
`timescale 1ns / 1ps

module obrb_ctrl #(
   parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [obrb_pkg::ACT_W-1:0]      action,
   input  logic [obrb_pkg::BYTE_W-1:0]     byte_in,
   input  logic [obrb_pkg::AMT_W-1:0]      amount,
   output logic                            ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]        ram_wr_addr,
   output logic [obrb_pkg::BYTE_W-1:0]     ram_wr_data,
   output logic                            ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]        ram_rd_addr,
   output obrb_pkg::step_result_type       result
);
   import obrb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (PTR_W > AMT_W) ? PTR_W : AMT_W;
   localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] ONE     = PTR_W'(1);

   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [PTR_W-1:0] next_wr_ff, next_wr_in;
   logic [PTR_W-1:0] held_ff, held_in;

   logic [CMP_W-1:0] amt_x, held_x;
   logic [PTR_W-1:0] amt_p;
   logic             amt_over, held_zero, read_hit;
   logic             step_status, step_read_hit;
   action_type       act;

   // (p + n) mod DEPTH, valid for n < DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] n);
      logic [PTR_W:0] s;
      s = {1'b0, p} + {1'b0, n};
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[PTR_W-1:0];
   endfunction

   // (p - n) mod DEPTH, valid for n <= DEPTH
   function automatic logic [PTR_W-1:0] wrap_sub(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] n);
      logic [PTR_W:0] s;
      s = {1'b0, p} + DEPTH_X - {1'b0, n};
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[PTR_W-1:0];
   endfunction

   assign act       = action_type'(action);
   assign amt_x     = CMP_W'(amount);
   assign held_x    = CMP_W'(held_ff);
   assign amt_p     = amt_x[PTR_W-1:0];
   assign amt_over  = amt_x > held_x;
   assign held_zero = held_ff == '0;
   assign read_hit  = amt_x < held_x;

   always_comb begin
      oldest_in     = oldest_ff;
      next_wr_in    = next_wr_ff;
      held_in       = held_ff;
      step_status   = STATUS_OK;
      step_read_hit = 1'b0;
      case (act)
         ACT_PUT: begin
            if (held_ff == LAST) oldest_in = wrap_add(oldest_ff, ONE);
            else held_in = held_ff + ONE;
            next_wr_in = wrap_add(next_wr_ff, ONE);
         end
         ACT_POP_FRONT: begin
            if (held_zero) begin
               step_status = STATUS_ERR;
            end else begin
               held_in   = held_ff - ONE;
               oldest_in = wrap_add(oldest_ff, ONE);
            end
         end
         ACT_POP_BACK: begin
            if (held_zero) begin
               step_status = STATUS_ERR;
            end else begin
               held_in    = held_ff - ONE;
               next_wr_in = wrap_sub(next_wr_ff, ONE);
            end
         end
         ACT_POP_FRONTN: begin
            if (amt_over) begin
               step_status = STATUS_ERR;
            end else begin
               held_in   = held_ff - amt_p;
               oldest_in = wrap_add(oldest_ff, amt_p);
            end
         end
         ACT_POP_BACKN: begin
            if (amt_over) begin
               step_status = STATUS_ERR;
            end else begin
               held_in    = held_ff - amt_p;
               next_wr_in = wrap_sub(next_wr_ff, amt_p);
            end
         end
         ACT_READ: begin
            step_read_hit = read_hit;
         end
         ACT_CLEAR: begin
            oldest_in  = '0;
            next_wr_in = '0;
            held_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // Flags reflect the count after this transfer
   logic [CMP_W-1:0] held_in_x;
   assign held_in_x = CMP_W'(held_in);
   assign result    = {step_status, step_read_hit, (held_in == LAST), (held_in == '0),
                       held_in_x[LEN_W-1:0]};

   assign ram_wr_en   = accept && (act == ACT_PUT);
   assign ram_wr_addr = next_wr_ff;
   assign ram_wr_data = byte_in;
   assign ram_rd_en   = accept && (act == ACT_READ) && read_hit;
   assign ram_rd_addr = wrap_add(oldest_ff, amt_p);

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         next_wr_ff <= '0;
         held_ff    <= '0;
      end else if (accept) begin
         oldest_ff  <= oldest_in;
         next_wr_ff <= next_wr_in;
         held_ff    <= held_in;
      end
   end

endmodule

>>> src/overwriting_byte_ring_buffer.sv
// Top level of the overwriting byte ring buffer.
// Depends on obrb_pkg, obrb_if, obrb_ram and obrb_ctrl.
`timescale 1ns / 1ps

// Usage
//  req: one transfer per operation (action, byte_in, amount). Puts always
//       succeed; on a full ring the oldest byte is dropped.
//  rsp: exactly one transfer per request, in request order, carrying status,
//       byte_out (reads only, else 0), length and the full/empty flags as
//       they stand after the operation.
//  Path: the response passes through the pending stage and then the output
//       register; the pending stage covers the registered read of the slot RAM.
//  Throughput: one operation per cycle unless rsp stalls. Pointers and count
//       update in the cycle of the transfer, so the next request is decoded
//       against them at once; a read issued right after a put sees the new
//       byte, since the put has been written before the read address is sampled.
//  Stalls: a pending stage and the output register part the two sides, so
//       req stays ready while one response waits; with both full and rsp
//       stalled, req.ready drops until rsp.ready returns.
//  Reset: synchronous, empties the ring and drops any pending response.
//       Slot contents are not cleared; only written slots are ever read.
module overwriting_byte_ring_buffer #(
   parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   obrb_req_if.sink   req,
   obrb_rsp_if.source rsp
);
   import obrb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   logic                accept;
   logic                out_free;

   logic                ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0]   ram_wr_data, ram_rd_data;
   step_result_type     step_res;

   // Pending stage: result of the last transfer, waiting on RAM read data
   logic                pend_valid_ff, pend_valid_in;
   step_result_type     pend_res_ff;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [LEN_W-1:0]    rsp_length_ff;
   logic                rsp_full_ff, rsp_empty_ff;
   logic                load_out;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !pend_valid_ff || out_free;
   assign accept    = req.valid && req.ready;
   assign load_out  = pend_valid_ff && out_free;

   obrb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req.action),
      .byte_in     (req.byte_in),
      .amount      (req.amount),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .result      (step_res)
   );

   // Read data is held by the RAM until the next read, which can only be
   // issued once the pending stage has moved on.
   obrb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) pend_valid_in = 1'b1;
      else if (load_out) pend_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_res_ff <= step_res;
      end
      if (load_out) begin
         rsp_status_ff <= pend_res_ff.status;
         rsp_byte_ff   <= pend_res_ff.read_hit ? ram_rd_data : '0;
         rsp_length_ff <= pend_res_ff.length;
         rsp_full_ff   <= pend_res_ff.full_flag;
         rsp_empty_ff  <= pend_res_ff.empty_flag;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.byte_out   = rsp_byte_ff;
   assign rsp.length     = rsp_length_ff;
   assign rsp.full_flag  = rsp_full_ff;
   assign rsp.empty_flag = rsp_empty_ff;

   // Checks
   a_accept_fills_pending: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_valid_ff)
      else $error("request transfer did not reach the pending stage");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !out_free) |=> (pend_valid_ff && $stable(pend_res_ff)))
      else $error("pending result lost or changed while output stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.full_flag && rsp.empty_flag))
      else $error("response flags full and empty together");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_ERR) |-> (rsp.byte_out == '0))
      else $error("failed operation returned read data");

endmodule
